// ===== rtl/core/ptu_pkg.sv =====
package ptu_pkg;

    localparam int REM_W      = 20;
    localparam int DIV_STEPS  = 7;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int MAC_LAST   = 4;
    localparam int QUOT_STEP  = 5;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [REM_W-1:0] US_PER_S      = 20'd1000000;
    localparam logic [REM_W-1:0] US_PER_MS     = 20'd1000;
    localparam logic [31:0]      TIMEOUT_RESET = 32'd2000000;
    localparam logic [31:0]      AGE_UNKNOWN   = 32'hFFFF_FFFF;

    // One second is 2^6 * 15625 microseconds. The odd factor is divided by a
    // 59-bit reciprocal that is exact for any 58-bit numerator.
    localparam logic [13:0] SEC_ODD        = 14'd15625;
    localparam logic [72:0] SEC_RECIP_WIDE = ((73'd1 << 72) + 73'd15624) / 73'd15625;
    localparam logic [58:0] SEC_RECIP      = SEC_RECIP_WIDE[58:0];
    // Reciprocal of 1000, exact for numerators below one million.
    localparam logic [20:0] MS_RECIP       = 21'(((1 << 30) + 999) / 1000);

    typedef enum logic [1:0] {
        K_EDGE  = 2'd0,
        K_APPLY = 2'd1,
        K_STAMP = 2'd2,
        K_TICK  = 2'd3
    } kind_t;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        kind_t        kind;
        logic [63:0]  diff;
        logic         early;
        logic         nocap;
        logic         take;
        logic [31:0]  epoch;
        logic         fix;
    } item_t;

endpackage

// ===== rtl/core/pps_timestamp_unit_top.sv =====
// An edge or apply item goes from the queue straight to the output state; a stamp or
// health tick first passes through the seven-step reciprocal divider. The result side
// can stall the output. The back end works on one item at a time and pops the next only
// when it is idle; a two-entry queue decouples the input.
// Reset is asynchronous and active low: no capture, no pending apply, time invalid,
// epoch and fix cleared, timeout back at two seconds.
module pps_timestamp_unit_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  func,
    input  logic [63:0] time_us,
    input  logic [31:0] epoch_in,
    input  logic        fix_in,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] sec_out,
    output logic [19:0] frac_us,
    output logic        stamp_ok,
    output logic [31:0] age_ms,
    output logic        valid_now,
    output logic        fix_now,
    output logic [31:0] epoch_now
);
    import ptu_pkg::*;

    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    ptu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .func       (func),
        .time_us    (time_us),
        .epoch_in   (epoch_in),
        .fix_in     (fix_in),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    ptu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sec_out      (sec_out),
        .frac_us      (frac_us),
        .stamp_ok     (stamp_ok),
        .age_ms       (age_ms),
        .valid_now    (valid_now),
        .fix_now      (fix_now),
        .epoch_now    (epoch_now)
    );

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (frac_us < US_PER_S))
        else $error("fraction out of range");

    a_ok_implies_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && stamp_ok) |-> valid_now)
        else $error("stamp marked ok while time invalid");

    a_tick_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (age_ms != 32'd0))
            |-> (sec_out == 32'd0 && frac_us == 20'd0 && !stamp_ok))
        else $error("stamp fields set on a health tick result");

endmodule

// ===== rtl/core/ptu_cdiv.sv =====
module ptu_cdiv (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [63:0]           dividend,
    output logic                  done,
    output logic [31:0]           quot,
    output logic [19:0]           rem,
    output logic [31:0]           quot_ms
);
    import ptu_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [57:0]          num_reg;
    logic [5:0]           low_reg;
    logic [58:0]          pp_reg;
    logic [116:0]         acc_reg;
    logic [31:0]          quot_reg;
    logic [19:0]          rem_reg;
    logic [31:0]          ms_reg;
    logic [28:0]          mul_a;
    logic [29:0]          mul_b;
    logic [116:0]         pp_shifted;
    logic [31:0]          q_low;
    logic [27:0]          q_odd_prod;
    logic [13:0]          rem_odd;
    logic [40:0]          ms_frac_prod;
    logic                 last;

    // Steps 0 to 3 form one 29x30 partial product each, steps 1 to 4 add the
    // previous one into the accumulator, step 5 takes the quotient and the
    // remainder, step 6 derives the millisecond quotient from them.
    always_comb
    begin
        mul_a = num_reg[28:0];
        mul_b = SEC_RECIP[29:0];
        case (cnt_reg)
            DIV_CNT_W'(1):
            begin
                mul_a = num_reg[57:29];
                mul_b = SEC_RECIP[29:0];
            end
            DIV_CNT_W'(2):
            begin
                mul_a = num_reg[28:0];
                mul_b = {1'b0, SEC_RECIP[58:30]};
            end
            DIV_CNT_W'(3):
            begin
                mul_a = num_reg[57:29];
                mul_b = {1'b0, SEC_RECIP[58:30]};
            end
            default:
            begin
                mul_a = num_reg[28:0];
                mul_b = SEC_RECIP[29:0];
            end
        endcase
    end

    always_comb
    begin
        case (cnt_reg)
            DIV_CNT_W'(2): pp_shifted = {29'd0, pp_reg, 29'd0};
            DIV_CNT_W'(3): pp_shifted = {28'd0, pp_reg, 30'd0};
            DIV_CNT_W'(4): pp_shifted = {pp_reg[57:0], 59'd0};
            default:       pp_shifted = {58'd0, pp_reg};
        endcase
    end

    // The true remainder is below 2^14, so the low bits of the product suffice.
    assign q_low        = acc_reg[103:72];
    assign q_odd_prod   = {14'd0, q_low[13:0]} * {14'd0, SEC_ODD};
    assign rem_odd      = num_reg[13:0] - q_odd_prod[13:0];
    assign ms_frac_prod = {21'd0, rem_reg} * {20'd0, MS_RECIP};

    assign last = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend[63:6];
            low_reg <= dividend[5:0];
            pp_reg  <= '0;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            pp_reg <= {30'd0, mul_a} * {29'd0, mul_b};
            if (cnt_reg <= DIV_CNT_W'(MAC_LAST))
                acc_reg <= acc_reg + pp_shifted;
            if (cnt_reg == DIV_CNT_W'(QUOT_STEP))
            begin
                quot_reg <= q_low;
                rem_reg  <= {rem_odd, low_reg};
            end
            if (last)
                ms_reg <= quot_reg * {12'd0, US_PER_MS} + {21'd0, ms_frac_prod[40:30]};
        end
    end

    assign done    = done_reg;
    assign quot    = quot_reg;
    assign rem     = rem_reg;
    assign quot_ms = ms_reg;

endmodule

// ===== rtl/core/ptu_front.sv =====
module ptu_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  logic [1:0]      func,
    input  logic [63:0]     time_us,
    input  logic [31:0]     epoch_in,
    input  logic            fix_in,
    output logic            q_valid,
    output ptu_pkg::item_t  q_item,
    input  logic            q_pop
);
    import ptu_pkg::*;

    logic [63:0]       capture_reg;
    logic              pending_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    item_t             fifo_reg [QDEPTH];
    item_t             push_item;
    logic [64:0]       diff_ext;
    logic              accept;

    assign item_stall = (count_reg == QCNT_W'(QDEPTH));
    assign accept     = item_valid && !item_stall;
    assign q_valid    = (count_reg != '0);
    assign q_item     = fifo_reg[rd_ptr_reg];

    // The borrow of the subtraction tells whether the time lies before the capture.
    assign diff_ext = {1'b0, time_us} - {1'b0, capture_reg};

    always_comb
    begin
        push_item.kind   = kind_t'(func);
        push_item.diff   = diff_ext[63:0];
        push_item.early  = diff_ext[64];
        push_item.nocap  = (capture_reg == 64'd0);
        push_item.take   = (kind_t'(func) == K_APPLY) && pending_reg;
        push_item.epoch  = epoch_in;
        push_item.fix    = fix_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capture_reg <= '0;
            pending_reg <= 1'b0;
            count_reg   <= '0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                case (kind_t'(func))
                    K_EDGE:
                    begin
                        capture_reg <= time_us;
                        pending_reg <= 1'b1;
                    end
                    K_APPLY:
                    begin
                        pending_reg <= 1'b0;
                    end
                    default:
                    begin
                        pending_reg <= pending_reg;
                    end
                endcase
                wr_ptr_reg <= QPTR_W'(wr_ptr_reg + 1'b1);
            end
            if (q_pop)
                rd_ptr_reg <= QPTR_W'(rd_ptr_reg + 1'b1);
            if (accept && !q_pop)
                count_reg <= count_reg + 1'b1;
            else if (!accept && q_pop)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            fifo_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== rtl/core/ptu_back.sv =====
module ptu_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  ptu_pkg::item_t  q_item,
    output logic            q_pop,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [31:0]     cfg_data,
    output logic            result_valid,
    input  logic            result_stall,
    output logic [31:0]     sec_out,
    output logic [19:0]     frac_us,
    output logic            stamp_ok,
    output logic [31:0]     age_ms,
    output logic            valid_now,
    output logic            fix_now,
    output logic [31:0]     epoch_now
);
    import ptu_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_DIV  = 3'b010,
        B_OUT  = 3'b100
    } bstate_t;

    bstate_t     state_reg, state_next;
    item_t       cur_reg;
    logic [31:0] timeout_reg;
    logic [31:0] epoch_reg, epoch_next;
    logic        fix_reg, fix_next;
    logic        valid_reg, valid_next;
    logic        res_valid_reg;
    logic [31:0] sec_reg, sec_next;
    logic [19:0] frac_reg, frac_next;
    logic        ok_reg, ok_next;
    logic [31:0] age_reg, age_next;
    logic        emit;
    logic        slot_free;
    logic        div_start;
    logic [63:0] dividend_s;
    logic        done_s;
    logic [31:0] quot_s;
    logic [31:0] quot_ms;
    logic [19:0] rem_s;

    // Clamped difference for a stamp, raw difference for a tick; the
    // millisecond quotient is only used on a tick.
    assign dividend_s = (q_item.kind == K_STAMP && q_item.diff[63]) ? 64'd0 : q_item.diff;

    ptu_cdiv u_div_s (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend_s),
        .done     (done_s),
        .quot     (quot_s),
        .rem      (rem_s),
        .quot_ms  (quot_ms)
    );

    assign cfg_ready = 1'b1;
    assign slot_free = !res_valid_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        div_start  = 1'b0;
        emit       = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_item.kind == K_STAMP || q_item.kind == K_TICK)
                    begin
                        div_start  = 1'b1;
                        state_next = B_DIV;
                    end
                    else
                    begin
                        state_next = B_OUT;
                    end
                end
            end
            B_DIV:
            begin
                if (done_s)
                    state_next = B_OUT;
            end
            B_OUT:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        epoch_next = epoch_reg;
        fix_next   = fix_reg;
        valid_next = valid_reg;
        sec_next   = '0;
        frac_next  = '0;
        ok_next    = 1'b0;
        age_next   = '0;
        case (cur_reg.kind)
            K_APPLY:
            begin
                if (cur_reg.take)
                begin
                    epoch_next = cur_reg.epoch;
                    fix_next   = cur_reg.fix;
                    valid_next = 1'b1;
                end
            end
            K_STAMP:
            begin
                if (!cur_reg.nocap)
                begin
                    sec_next  = epoch_reg + quot_s;
                    frac_next = rem_s;
                    ok_next   = valid_reg;
                end
            end
            K_TICK:
            begin
                age_next = (cur_reg.nocap || cur_reg.early) ? AGE_UNKNOWN : quot_ms;
                if (!cur_reg.nocap && (cur_reg.diff > {32'd0, timeout_reg}))
                begin
                    if (valid_reg)
                        epoch_next = epoch_reg + quot_s;
                    valid_next = 1'b0;
                end
            end
            default:
            begin
                epoch_next = epoch_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            timeout_reg   <= TIMEOUT_RESET;
            epoch_reg     <= '0;
            fix_reg       <= 1'b0;
            valid_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= emit || (res_valid_reg && result_stall);
            if (cfg_valid && cfg_ready)
                timeout_reg <= cfg_data;
            if (emit)
            begin
                epoch_reg <= epoch_next;
                fix_reg   <= fix_next;
                valid_reg <= valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_item;
        if (emit)
        begin
            sec_reg  <= sec_next;
            frac_reg <= frac_next;
            ok_reg   <= ok_next;
            age_reg  <= age_next;
        end
    end

    // The epoch, fix and time-valid registers only change on a transfer into the output register.
    assign result_valid = res_valid_reg;
    assign sec_out      = sec_reg;
    assign frac_us      = frac_reg;
    assign stamp_ok     = ok_reg;
    assign age_ms       = age_reg;
    assign valid_now    = valid_reg;
    assign fix_now      = fix_reg;
    assign epoch_now    = epoch_reg;

endmodule
